[src/sll_pkg.sv]
package sll_pkg;

	// widths and sizes
	localparam int POS_BITS    = 16;
	localparam int KW_MAX_LEN  = 6;
	localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
	localparam int KW_BITS     = 8 * KW_MAX_LEN;
	localparam int NUM_KW      = 16;
	localparam int RES_MAX     = 4;
	localparam int RES_IDX_BITS = $clog2(RES_MAX);
	localparam int CNT_BITS    = $clog2(RES_MAX + 1);
	localparam int FIELD_BITS  = 16;

	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [5:0]            kind_t;
	typedef logic [1:0]            err_t;
	typedef logic [7:0]            byte_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [KW_MAX_LEN-1:0][7:0] prefix_t;

	// scanner modes
	typedef enum logic [3:0] {
		M_IDLE,
		M_BANG,
		M_EQUAL,
		M_LESS,
		M_GREATER,
		M_SLASH,
		M_COMMENT,
		M_STRING,
		M_NUMBER,
		M_NUMDOT,
		M_NUMFRAC,
		M_WORD
	} lex_mode_t;

	// token kinds
	localparam kind_t K_LPAREN   = 6'd0;
	localparam kind_t K_RPAREN   = 6'd1;
	localparam kind_t K_LBRACE   = 6'd2;
	localparam kind_t K_RBRACE   = 6'd3;
	localparam kind_t K_COMMA    = 6'd4;
	localparam kind_t K_DOT      = 6'd5;
	localparam kind_t K_MINUS    = 6'd6;
	localparam kind_t K_PLUS     = 6'd7;
	localparam kind_t K_SEMI     = 6'd8;
	localparam kind_t K_SLASH    = 6'd9;
	localparam kind_t K_STAR     = 6'd10;
	localparam kind_t K_BANG     = 6'd11;
	localparam kind_t K_EQ       = 6'd13;
	localparam kind_t K_GT       = 6'd15;
	localparam kind_t K_LT       = 6'd17;
	localparam kind_t K_IDENT    = 6'd19;
	localparam kind_t K_STRING   = 6'd20;
	localparam kind_t K_NUMBER   = 6'd21;
	localparam kind_t K_KW_FIRST = 6'd22;
	localparam kind_t K_EOF      = 6'd38;
	localparam kind_t K_ERROR    = 6'd0;

	// error codes
	localparam err_t E_NONE       = 2'd0;
	localparam err_t E_UNEXPECTED = 2'd1;
	localparam err_t E_UNTERM     = 2'd2;

	// characters
	localparam byte_t CH_LPAREN = "(";
	localparam byte_t CH_RPAREN = ")";
	localparam byte_t CH_LBRACE = "{";
	localparam byte_t CH_RBRACE = "}";
	localparam byte_t CH_COMMA  = ",";
	localparam byte_t CH_DOT    = ".";
	localparam byte_t CH_MINUS  = "-";
	localparam byte_t CH_PLUS   = "+";
	localparam byte_t CH_SEMI   = ";";
	localparam byte_t CH_STAR   = "*";
	localparam byte_t CH_BANG   = "!";
	localparam byte_t CH_EQ     = "=";
	localparam byte_t CH_LT     = "<";
	localparam byte_t CH_GT     = ">";
	localparam byte_t CH_SLASH  = "/";
	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_CR     = 8'h0D;
	localparam byte_t CH_TAB    = 8'h09;
	localparam byte_t CH_LF     = 8'h0A;
	localparam byte_t CH_UNDER  = "_";

	// keyword spellings, right aligned, in kind order
	localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
		KW_BITS'("and"),   KW_BITS'("class"), KW_BITS'("else"),   KW_BITS'("false"),
		KW_BITS'("fun"),   KW_BITS'("for"),   KW_BITS'("if"),     KW_BITS'("nil"),
		KW_BITS'("or"),    KW_BITS'("print"), KW_BITS'("return"), KW_BITS'("super"),
		KW_BITS'("this"),  KW_BITS'("true"),  KW_BITS'("var"),    KW_BITS'("while")
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
		4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
	};

	// one result item
	typedef struct packed {
		kind_t  kind;
		err_t   err;
		field_t start;
		field_t len;
		field_t line;
		logic   last;
	} res_t;

	// load request from the scanner core to the result buffer
	typedef struct packed {
		logic load;
		cnt_t count;
	} load_ctl_t;

	function automatic pos_t sat_add_pos(pos_t a, pos_t b);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
	endfunction

	function automatic field_t line_inc(field_t l);
		return (l == '1) ? l : field_t'(l + 1'b1);
	endfunction

	function automatic field_t clamp16(pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic is_digit(byte_t c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(byte_t c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
	endfunction

	function automatic res_t make_result(kind_t k, err_t e, pos_t start, pos_t len,
			field_t line);
		res_t r;
		r.kind  = k;
		r.err   = e;
		r.start = clamp16(start);
		r.len   = clamp16(len);
		r.line  = line;
		r.last  = 1'b0;
		return r;
	endfunction

	// identifier or keyword kind from the stored prefix
	function automatic kind_t keyword_kind(prefix_t p, pos_t len);
		logic [KW_BITS-1:0] word;
		kind_t k;
		word = '0;
		k = K_IDENT;
		for (int j = 0; j < KW_MAX_LEN; j++) begin
			if (pos_t'(j) < len) begin
				word = {word[KW_BITS-9:0], p[j]};
			end
		end
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if ((len == pos_t'(KW_LEN[i])) && (word == KW_TEXT[i])) begin
				k = kind_t'(K_KW_FIRST + kind_t'(i));
			end
		end
		return k;
	endfunction

	function automatic kind_t op_kind(lex_mode_t m, logic two);
		kind_t base;
		case (m)
			M_BANG:    base = K_BANG;
			M_EQUAL:   base = K_EQ;
			M_GREATER: base = K_GT;
			default:   base = K_LT;
		endcase
		return two ? kind_t'(base + 1'b1) : base;
	endfunction

endpackage

[src/script_language_lexer.sv]
// streaming lexer: one source byte per input item, tokens out as result items
// input channel: in_valid/in_ready with source_byte, has_byte, is_last;
//   has_byte 0 with is_last 1 only closes the source
// output channel: out_valid/out_ready with token_kind, error_code, start_pos,
//   lexeme_length, line_number and last_of_run (set on the final item of a run)
// an item sits in an input register, the scanner works on it combinationally and
//   loads up to four result items into the result buffer
// an accepted item passes the input register, then the result buffer, before its
//   first result can be taken; a full buffer holds it in the input register
// throughput: one input item per cycle while out_ready stays high and each item
//   gives at most one result; an item giving more results holds the input until
//   all but its last are taken, set by the single read port of the result buffer
// a new item is taken while the last result of the previous one is being taken
// when out_ready is low the buffer holds, the input register fills and
//   in_ready drops; nothing is lost
// reset clears the mode, position, token start and length and sets line to one;
//   after the end of source the scanner returns to the same state by itself
module script_language_lexer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sll_pkg::byte_t         source_byte,
	input  logic                   has_byte,
	input  logic                   is_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sll_pkg::kind_t         token_kind,
	output sll_pkg::err_t          error_code,
	output sll_pkg::field_t        start_pos,
	output sll_pkg::field_t        lexeme_length,
	output sll_pkg::field_t        line_number,
	output logic                   last_of_run
);
	import sll_pkg::*;

	logic  v_s1;
	byte_t byte_s1;
	logic  has_s1;
	logic  last_s1;
	logic  fire;
	logic  can_load;
	logic  accept;
	res_t [RES_MAX-1:0] res;
	cnt_t  count;
	res_t  head;
	load_ctl_t ctl;

	// input register handshake
	assign fire     = v_s1 && can_load;
	assign in_ready = !v_s1 || fire;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= source_byte;
			has_s1  <= has_byte;
			last_s1 <= is_last;
		end
	end

	// scanner core
	sll_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.c      (byte_s1),
		.has    (has_s1),
		.last   (last_s1),
		.res    (res),
		.count  (count)
	);

	assign ctl.load  = fire;
	assign ctl.count = count;

	// result buffer
	sll_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.res_in    (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// result fields
	assign token_kind    = head.kind;
	assign error_code    = head.err;
	assign start_pos     = head.start;
	assign lexeme_length = head.len;
	assign line_number   = head.line;
	assign last_of_run   = head.last;

endmodule

[src/sll_core.sv]
module sll_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    fire,
	input  sll_pkg::byte_t                          c,
	input  logic                                    has,
	input  logic                                    last,
	output sll_pkg::res_t [sll_pkg::RES_MAX-1:0]    res,
	output sll_pkg::cnt_t                           count
);
	import sll_pkg::*;

	localparam int NCAND = 6;

	lex_mode_t mode_q, mode_f, mode_n;
	pos_t      position_q, pos_f, position_n;
	pos_t      start_q, start_f, start_n;
	pos_t      len_q, len_f, len_n, len_inc;
	field_t    line_q, line_f, line_n;
	prefix_t   prefix_q, prefix_f;
	logic      run_idle;
	kind_t     idle_kind;
	err_t      idle_err;
	logic      idle_emit;
	res_t [NCAND-1:0] cand;
	logic [NCAND-1:0] cand_v;
	res_t [RES_MAX-1:0] res_c;
	cnt_t      n;

	// feed the byte to the current mode
	always_comb begin
		mode_f    = mode_q;
		start_f   = start_q;
		len_f     = len_q;
		line_f    = line_q;
		prefix_f  = prefix_q;
		run_idle  = 1'b0;
		idle_kind = K_ERROR;
		idle_err  = E_NONE;
		idle_emit = 1'b0;
		cand      = '0;
		cand_v    = '0;
		len_inc   = sat_add_pos(len_q, pos_t'(1));
		if (has) begin
			case (mode_q)
				M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
					if (c == CH_EQ) begin
						cand[0]   = make_result(op_kind(mode_q, 1'b1), E_NONE, start_q,
							pos_t'(2), line_q);
						cand_v[0] = 1'b1;
						mode_f    = M_IDLE;
					end else begin
						cand[0]   = make_result(op_kind(mode_q, 1'b0), E_NONE, start_q,
							pos_t'(1), line_q);
						cand_v[0] = 1'b1;
						run_idle  = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_f = M_COMMENT;
					end else begin
						cand[0]   = make_result(K_SLASH, E_NONE, start_q, pos_t'(1), line_q);
						cand_v[0] = 1'b1;
						run_idle  = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == CH_LF) begin
						line_f = line_inc(line_q);
						mode_f = M_IDLE;
					end
				end
				M_STRING: begin
					len_f = len_inc;
					if (c == CH_QUOTE) begin
						cand[0]   = make_result(K_STRING, E_NONE, start_q, len_inc, line_q);
						cand_v[0] = 1'b1;
						mode_f    = M_IDLE;
					end else if (c == CH_LF) begin
						line_f = line_inc(line_q);
					end
				end
				M_NUMBER, M_NUMFRAC: begin
					if (is_digit(c)) begin
						len_f = len_inc;
					end else if ((c == CH_DOT) && (mode_q == M_NUMBER)) begin
						mode_f = M_NUMDOT;
					end else begin
						cand[0]   = make_result(K_NUMBER, E_NONE, start_q, len_q, line_q);
						cand_v[0] = 1'b1;
						run_idle  = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_digit(c)) begin
						len_f  = sat_add_pos(len_q, pos_t'(2));
						mode_f = M_NUMFRAC;
					end else begin
						cand[0]   = make_result(K_NUMBER, E_NONE, start_q, len_q, line_q);
						cand_v[0] = 1'b1;
						cand[1]   = make_result(K_DOT, E_NONE, sat_add_pos(start_q, len_q),
							pos_t'(1), line_q);
						cand_v[1] = 1'b1;
						run_idle  = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (len_q < pos_t'(KW_MAX_LEN)) begin
							prefix_f[len_q[KW_IDX_BITS-1:0]] = c;
						end
						len_f = len_inc;
					end else begin
						cand[0]   = make_result(keyword_kind(prefix_q, len_q), E_NONE,
							start_q, len_q, line_q);
						cand_v[0] = 1'b1;
						run_idle  = 1'b1;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase
		end

		// byte seen from the idle mode
		if (run_idle) begin
			mode_f = M_IDLE;
			case (c)
				CH_LPAREN: begin idle_kind = K_LPAREN; idle_emit = 1'b1; end
				CH_RPAREN: begin idle_kind = K_RPAREN; idle_emit = 1'b1; end
				CH_LBRACE: begin idle_kind = K_LBRACE; idle_emit = 1'b1; end
				CH_RBRACE: begin idle_kind = K_RBRACE; idle_emit = 1'b1; end
				CH_COMMA:  begin idle_kind = K_COMMA;  idle_emit = 1'b1; end
				CH_DOT:    begin idle_kind = K_DOT;    idle_emit = 1'b1; end
				CH_MINUS:  begin idle_kind = K_MINUS;  idle_emit = 1'b1; end
				CH_PLUS:   begin idle_kind = K_PLUS;   idle_emit = 1'b1; end
				CH_SEMI:   begin idle_kind = K_SEMI;   idle_emit = 1'b1; end
				CH_STAR:   begin idle_kind = K_STAR;   idle_emit = 1'b1; end
				CH_BANG:   begin mode_f = M_BANG;    start_f = position_q; len_f = pos_t'(1); end
				CH_EQ:     begin mode_f = M_EQUAL;   start_f = position_q; len_f = pos_t'(1); end
				CH_LT:     begin mode_f = M_LESS;    start_f = position_q; len_f = pos_t'(1); end
				CH_GT:     begin mode_f = M_GREATER; start_f = position_q; len_f = pos_t'(1); end
				CH_SLASH:  begin mode_f = M_SLASH;   start_f = position_q; len_f = pos_t'(1); end
				CH_QUOTE:  begin mode_f = M_STRING;  start_f = position_q; len_f = pos_t'(1); end
				CH_SPACE, CH_CR, CH_TAB: begin
				end
				CH_LF: begin
					line_f = line_inc(line_q);
				end
				default: begin
					if (is_digit(c)) begin
						mode_f  = M_NUMBER;
						start_f = position_q;
						len_f   = pos_t'(1);
					end else if (is_alpha(c)) begin
						mode_f      = M_WORD;
						start_f     = position_q;
						len_f       = pos_t'(1);
						prefix_f[0] = c;
					end else begin
						idle_kind = K_ERROR;
						idle_err  = E_UNEXPECTED;
						idle_emit = 1'b1;
					end
				end
			endcase
		end
		cand[2]   = make_result(idle_kind, idle_err, position_q, pos_t'(1), line_q);
		cand_v[2] = idle_emit;

		pos_f = has ? sat_add_pos(position_q, pos_t'(1)) : position_q;

		// end of source: flush the pending token, then eof
		if (last) begin
			case (mode_f)
				M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
					cand[3]   = make_result(op_kind(mode_f, 1'b0), E_NONE, start_f,
						pos_t'(1), line_f);
					cand_v[3] = 1'b1;
				end
				M_SLASH: begin
					cand[3]   = make_result(K_SLASH, E_NONE, start_f, pos_t'(1), line_f);
					cand_v[3] = 1'b1;
				end
				M_STRING: begin
					cand[3]   = make_result(K_ERROR, E_UNTERM, start_f, len_f, line_f);
					cand_v[3] = 1'b1;
				end
				M_NUMBER, M_NUMFRAC: begin
					cand[3]   = make_result(K_NUMBER, E_NONE, start_f, len_f, line_f);
					cand_v[3] = 1'b1;
				end
				M_NUMDOT: begin
					cand[3]   = make_result(K_NUMBER, E_NONE, start_f, len_f, line_f);
					cand_v[3] = 1'b1;
					cand[4]   = make_result(K_DOT, E_NONE, sat_add_pos(start_f, len_f),
						pos_t'(1), line_f);
					cand_v[4] = 1'b1;
				end
				M_WORD: begin
					cand[3]   = make_result(keyword_kind(prefix_f, len_f), E_NONE, start_f,
						len_f, line_f);
					cand_v[3] = 1'b1;
				end
				default: begin
				end
			endcase
			cand[5]   = make_result(K_EOF, E_NONE, pos_f, pos_t'(0), line_f);
			cand_v[5] = 1'b1;
		end
	end

	// next state, back to reset values after the end of source
	always_comb begin
		if (last) begin
			mode_n     = M_IDLE;
			position_n = '0;
			start_n    = '0;
			len_n      = '0;
			line_n     = field_t'(1);
		end else begin
			mode_n     = mode_f;
			position_n = pos_f;
			start_n    = start_f;
			len_n      = len_f;
			line_n     = line_f;
		end
	end

	// pack the produced results in order and mark the final one
	always_comb begin
		n     = '0;
		res_c = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_v[i] && (n < cnt_t'(RES_MAX))) begin
				res_c[n[RES_IDX_BITS-1:0]] = cand[i];
				n = cnt_t'(n + 1'b1);
			end
		end
		for (int k = 0; k < RES_MAX; k++) begin
			res_c[k].last = (cnt_t'(k) == cnt_t'(n - 1'b1));
		end
	end

	assign res   = res_c;
	assign count = n;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			position_q <= '0;
			start_q    <= '0;
			len_q      <= '0;
			line_q     <= field_t'(1);
		end else if (fire) begin
			mode_q     <= mode_n;
			position_q <= position_n;
			start_q    <= start_n;
			len_q      <= len_n;
			line_q     <= line_n;
		end
	end

	// identifier prefix bytes
	always_ff @(posedge clk) begin
		if (fire) begin
			prefix_q <= prefix_f;
		end
	end

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count reached zero");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> (mode_q == M_IDLE) && (position_q == '0) && (line_q == field_t'(1)))
		else $error("state not cleared after end of source");

	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !has && !last |-> (count == '0))
		else $error("empty item produced a result");

	a_last_eof: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |-> (count != '0))
		else $error("end of source without eof result");

endmodule

[src/sll_obuf.sv]
module sll_obuf (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sll_pkg::load_ctl_t                      ctl,
	input  sll_pkg::res_t [sll_pkg::RES_MAX-1:0]    res_in,
	output logic                                    can_load,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output sll_pkg::res_t                           head
);
	import sll_pkg::*;

	res_t [RES_MAX-1:0] buf_q;
	cnt_t               cnt_q;
	logic               pop;

	// handshake and load window
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign can_load  = (cnt_q == '0) || ((cnt_q == cnt_t'(1)) && out_ready);
	assign head      = buf_q[0];

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= ctl.count;
		end else if (pop) begin
			cnt_q <= cnt_t'(cnt_q - 1'b1);
		end
	end

	// result slots, shifted toward the head on each taken item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			buf_q <= res_in;
		end else if (pop) begin
			buf_q[RES_MAX-2:0] <= buf_q[RES_MAX-1:1];
		end
	end

	a_load_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> can_load)
		else $error("results loaded over waiting items");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(RES_MAX))
		else $error("result count out of range");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !ctl.load |=> cnt_q == cnt_t'($past(cnt_q) - 1'b1))
		else $error("count did not follow a taken item");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head.last == (cnt_q == cnt_t'(1))))
		else $error("last flag out of place");

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sll_pkg::*;

	localparam pos_t POS_LIMIT = '1;
	localparam field_t LINE_LIMIT = 16'hFFFF;

	// directed row: one item, with a hand-written token where it is obvious
	typedef struct {
		byte_t  ch;
		logic   has;
		logic   fin;
		logic   typed;
		kind_t  kind;
		err_t   err;
		field_t start;
		field_t len;
		field_t line;
	} dir_row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	byte_t  source_byte = '0;
	logic   has_byte = 1'b0;
	logic   is_last = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	kind_t  token_kind;
	err_t   error_code;
	field_t start_pos;
	field_t lexeme_length;
	field_t line_number;
	logic   last_of_run;

	// scanner state mirrored by the predictor
	lex_mode_t scan_mode;
	pos_t      scan_pos;
	pos_t      tok_start;
	pos_t      tok_len;
	field_t    scan_line;
	byte_t     id_prefix [KW_MAX_LEN];

	res_t  expected_tokens [$];
	int    run_count;
	int    fed_items;
	int    fail_count;
	int    snd_idle_pct;
	int    rcv_stall_pct;
	byte_t src_bytes [$];

	string kw_spell [NUM_KW] = '{"and", "class", "else", "false", "fun", "for", "if",
		"nil", "or", "print", "return", "super", "this", "true", "var", "while"};
	string punct_chars = "(){},.-+;*";
	string op_text [9] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/"};
	string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string blank_chars = " \t\r\n";

	int snd_phase_pct [4] = '{0, 60, 0, 26};
	int rcv_phase_pct [4] = '{0, 0, 60, 26};

	dir_row_t dir_rows [27] = '{
		'{CH_LPAREN, 1'b1, 1'b0, 1'b1, K_LPAREN, E_NONE, 16'd0, 16'd1, 16'd1},
		'{"@", 1'b1, 1'b0, 1'b1, K_ERROR, E_UNEXPECTED, 16'd1, 16'd1, 16'd1},
		'{8'hFF, 1'b1, 1'b0, 1'b1, K_ERROR, E_UNEXPECTED, 16'd2, 16'd1, 16'd1},
		'{8'h00, 1'b1, 1'b0, 1'b1, K_ERROR, E_UNEXPECTED, 16'd3, 16'd1, 16'd1},
		'{CH_BANG, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_EQ, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"1", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_DOT, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_SEMI, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"2", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_DOT, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"5", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_LF, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_LF, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_SLASH, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_SLASH, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_LF, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{8'hA5, 1'b0, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_QUOTE, 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"a", 1'b1, 1'b1, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{8'h5A, 1'b0, 1'b1, 1'b1, K_EOF, E_NONE, 16'd0, 16'd0, 16'd1},
		'{"v", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"a", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{"r", 1'b1, 1'b0, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0},
		'{CH_GT, 1'b1, 1'b1, 1'b0, K_ERROR, E_NONE, 16'd0, 16'd0, 16'd0}
	};

	script_language_lexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_byte   (source_byte),
		.has_byte      (has_byte),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.error_code    (error_code),
		.start_pos     (start_pos),
		.lexeme_length (lexeme_length),
		.line_number   (line_number),
		.last_of_run   (last_of_run)
	);

	always #10 clk = ~clk;

	// ---------------- token predictor ----------------

	function automatic pos_t pos_add(pos_t a, int unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return (s > longint'(POS_LIMIT)) ? POS_LIMIT : pos_t'(s);
	endfunction

	function automatic field_t bump_line(field_t l);
		return (l == LINE_LIMIT) ? l : field_t'(l + 1'b1);
	endfunction

	function automatic field_t to_field(pos_t v);
		return (longint'(v) > 65535) ? 16'hFFFF : field_t'(v);
	endfunction

	function automatic logic digit_char(byte_t c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic word_char(byte_t c);
		return (c inside {["a":"z"], ["A":"Z"]}) || (c == CH_UNDER);
	endfunction

	function automatic void clear_scan();
		scan_mode = M_IDLE;
		scan_pos  = '0;
		tok_start = '0;
		tok_len   = '0;
		scan_line = 16'd1;
		foreach (id_prefix[i]) id_prefix[i] = '0;
	endfunction

	// append one token at the tail of the expected queue
	function automatic void queue_token(res_t r);
		expected_tokens.insert(expected_tokens.size(), r);
	endfunction

	function automatic void put_token(kind_t k, err_t e, pos_t st, pos_t ln);
		res_t r;
		r.kind  = k;
		r.err   = e;
		r.start = to_field(st);
		r.len   = to_field(ln);
		r.line  = scan_line;
		r.last  = 1'b0;
		queue_token(r);
		run_count++;
	endfunction

	function automatic void open_token(lex_mode_t m, pos_t p);
		scan_mode = m;
		tok_start = p;
		tok_len   = 1;
	endfunction

	// identifier, or keyword when the whole word matches a spelling
	function automatic kind_t word_kind();
		kind_t k;
		logic same;
		k = K_IDENT;
		if (tok_len <= KW_MAX_LEN) begin
			for (int i = 0; i < NUM_KW; i++) begin
				if (kw_spell[i].len() == int'(tok_len) && k == K_IDENT) begin
					same = 1'b1;
					for (int j = 0; j < kw_spell[i].len(); j++) begin
						if (kw_spell[i][j] != id_prefix[j]) same = 1'b0;
					end
					if (same) k = kind_t'(int'(K_KW_FIRST) + i);
				end
			end
		end
		return k;
	endfunction

	function automatic kind_t cmp_kind(lex_mode_t m, logic two);
		kind_t base;
		case (m)
			M_BANG:    base = K_BANG;
			M_EQUAL:   base = K_EQ;
			M_GREATER: base = K_GT;
			default:   base = K_LT;
		endcase
		return two ? kind_t'(base + 1) : base;
	endfunction

	function automatic void number_then_dot();
		put_token(K_NUMBER, E_NONE, tok_start, tok_len);
		put_token(K_DOT, E_NONE, pos_add(tok_start, tok_len), 1);
	endfunction

	// a byte seen outside any token
	function automatic void scan_idle(byte_t c, pos_t p);
		scan_mode = M_IDLE;
		case (c)
			CH_LPAREN: put_token(K_LPAREN, E_NONE, p, 1);
			CH_RPAREN: put_token(K_RPAREN, E_NONE, p, 1);
			CH_LBRACE: put_token(K_LBRACE, E_NONE, p, 1);
			CH_RBRACE: put_token(K_RBRACE, E_NONE, p, 1);
			CH_COMMA:  put_token(K_COMMA, E_NONE, p, 1);
			CH_DOT:    put_token(K_DOT, E_NONE, p, 1);
			CH_MINUS:  put_token(K_MINUS, E_NONE, p, 1);
			CH_PLUS:   put_token(K_PLUS, E_NONE, p, 1);
			CH_SEMI:   put_token(K_SEMI, E_NONE, p, 1);
			CH_STAR:   put_token(K_STAR, E_NONE, p, 1);
			CH_BANG:   open_token(M_BANG, p);
			CH_EQ:     open_token(M_EQUAL, p);
			CH_LT:     open_token(M_LESS, p);
			CH_GT:     open_token(M_GREATER, p);
			CH_SLASH:  open_token(M_SLASH, p);
			CH_QUOTE:  open_token(M_STRING, p);
			CH_SPACE, CH_CR, CH_TAB: ;
			CH_LF:     scan_line = bump_line(scan_line);
			default: begin
				if (digit_char(c)) begin
					open_token(M_NUMBER, p);
				end else if (word_char(c)) begin
					open_token(M_WORD, p);
					id_prefix[0] = c;
				end else begin
					put_token(K_ERROR, E_UNEXPECTED, p, 1);
				end
			end
		endcase
	endfunction

	function automatic void scan_byte(byte_t c, pos_t p);
		case (scan_mode)
			M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
				if (c == CH_EQ) begin
					put_token(cmp_kind(scan_mode, 1'b1), E_NONE, tok_start, 2);
					scan_mode = M_IDLE;
				end else begin
					put_token(cmp_kind(scan_mode, 1'b0), E_NONE, tok_start, 1);
					scan_idle(c, p);
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					scan_mode = M_COMMENT;
				end else begin
					put_token(K_SLASH, E_NONE, tok_start, 1);
					scan_idle(c, p);
				end
			end
			M_COMMENT: begin
				if (c == CH_LF) begin
					scan_line = bump_line(scan_line);
					scan_mode = M_IDLE;
				end
			end
			M_STRING: begin
				tok_len = pos_add(tok_len, 1);
				if (c == CH_QUOTE) begin
					put_token(K_STRING, E_NONE, tok_start, tok_len);
					scan_mode = M_IDLE;
				end else if (c == CH_LF) begin
					scan_line = bump_line(scan_line);
				end
			end
			M_NUMBER, M_NUMFRAC: begin
				if (digit_char(c)) begin
					tok_len = pos_add(tok_len, 1);
				end else if (c == CH_DOT && scan_mode == M_NUMBER) begin
					scan_mode = M_NUMDOT;
				end else begin
					put_token(K_NUMBER, E_NONE, tok_start, tok_len);
					scan_idle(c, p);
				end
			end
			M_NUMDOT: begin
				if (digit_char(c)) begin
					tok_len = pos_add(tok_len, 2);
					scan_mode = M_NUMFRAC;
				end else begin
					number_then_dot();
					scan_idle(c, p);
				end
			end
			M_WORD: begin
				if (word_char(c) || digit_char(c)) begin
					if (tok_len < KW_MAX_LEN) id_prefix[tok_len] = c;
					tok_len = pos_add(tok_len, 1);
				end else begin
					put_token(word_kind(), E_NONE, tok_start, tok_len);
					scan_idle(c, p);
				end
			end
			default: scan_idle(c, p);
		endcase
	endfunction

	// end of source: flush the open token, then EOF
	function automatic void close_source();
		case (scan_mode)
			M_BANG, M_EQUAL, M_LESS, M_GREATER:
				put_token(cmp_kind(scan_mode, 1'b0), E_NONE, tok_start, 1);
			M_SLASH:  put_token(K_SLASH, E_NONE, tok_start, 1);
			M_STRING: put_token(K_ERROR, E_UNTERM, tok_start, tok_len);
			M_NUMBER, M_NUMFRAC: put_token(K_NUMBER, E_NONE, tok_start, tok_len);
			M_NUMDOT: number_then_dot();
			M_WORD:   put_token(word_kind(), E_NONE, tok_start, tok_len);
			default: ;
		endcase
		put_token(K_EOF, E_NONE, scan_pos, 0);
	endfunction

	function automatic void predict_tokens(byte_t c, logic hb, logic lst);
		res_t r;
		run_count = 0;
		if (hb) begin
			scan_byte(c, scan_pos);
			scan_pos = pos_add(scan_pos, 1);
		end
		if (lst) begin
			close_source();
			clear_scan();
		end
		if (run_count > 0) begin
			r = expected_tokens.pop_back();
			r.last = 1'b1;
			queue_token(r);
		end
	endfunction

	// ---------------- stimulus ----------------

	task automatic send_item(byte_t b, logic hb, logic lst);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		source_byte = b;
		has_byte    = hb;
		is_last     = lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tokens(b, hb, lst);
		if (hb || lst) fed_items++;
		@(negedge clk);
	endtask

	// append one byte to the source text
	function automatic void add_src(byte_t b);
		src_bytes.insert(src_bytes.size(), b);
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) add_src(s[i]);
	endtask

	function automatic byte_t string_char();
		byte_t b;
		if ($urandom_range(0, 7) == 0) return CH_LF;
		b = byte_t'($urandom_range(32, 126));
		return (b == CH_QUOTE) ? byte_t'("'") : b;
	endfunction

	function automatic byte_t digit_byte();
		return byte_t'("0" + $urandom_range(0, 9));
	endfunction

	// one random lexeme appended to the source text
	task automatic add_lexeme();
		string w;
		byte_t b;
		case ($urandom_range(0, 11))
			0: add_src(punct_chars[$urandom_range(0, 9)]);
			1: push_text(op_text[$urandom_range(0, 8)]);
			2, 3: begin
				w = kw_spell[$urandom_range(0, NUM_KW - 1)];
				case ($urandom_range(0, 3))
					// clipped or extended spellings are plain identifiers
					0: push_text(w.substr(0, w.len() - 2));
					1: begin
						push_text(w);
						add_src(word_chars[$urandom_range(0, 62)]);
					end
					default: push_text(w);
				endcase
			end
			4: begin
				add_src(word_chars[$urandom_range(0, 52)]);
				repeat ($urandom_range(0, 8))
					add_src(word_chars[$urandom_range(0, 62)]);
			end
			5: begin
				repeat ($urandom_range(1, 4)) add_src(digit_byte());
				case ($urandom_range(0, 2))
					1: begin
						add_src(CH_DOT);
						repeat ($urandom_range(1, 3)) add_src(digit_byte());
					end
					2: add_src(CH_DOT);
					default: ;
				endcase
			end
			6: begin
				add_src(CH_QUOTE);
				repeat ($urandom_range(0, 6)) add_src(string_char());
				add_src(CH_QUOTE);
			end
			7: begin
				push_text("//");
				repeat ($urandom_range(0, 5)) begin
					b = byte_t'($urandom_range(0, 255));
					add_src((b == CH_LF) ? CH_SPACE : b);
				end
				add_src(CH_LF);
			end
			8, 9: add_src(blank_chars[$urandom_range(0, 3)]);
			default: add_src(byte_t'($urandom_range(0, 255)));
		endcase
	endtask

	// one whole source: lexemes, maybe an open string, then the end marker
	task automatic send_random_source();
		logic end_on_byte;
		src_bytes.delete();
		repeat ($urandom_range(0, 10)) begin
			add_lexeme();
			if ($urandom_range(0, 2) == 0) add_src(blank_chars[$urandom_range(0, 3)]);
		end
		if ($urandom_range(0, 5) == 0) begin
			add_src(CH_QUOTE);
			repeat ($urandom_range(0, 3)) add_src(string_char());
		end
		end_on_byte = (src_bytes.size() > 0) && ($urandom_range(0, 1) == 1);
		foreach (src_bytes[i]) begin
			if ($urandom_range(0, 11) == 0) send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(src_bytes[i], 1'b1, end_on_byte && (i == src_bytes.size() - 1));
		end
		if (!end_on_byte) send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// ---------------- result side ----------------

	always @(negedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	task automatic flag_field(string what, longint unsigned want, longint unsigned got);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		fail_count++;
	endtask

	// compare each taken item with the oldest expected token
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t ns: token with nothing expected, expected none, actual kind %0d",
					$time, token_kind);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind) flag_field("token_kind", want.kind, token_kind);
				if (error_code !== want.err) flag_field("error_code", want.err, error_code);
				if (start_pos !== want.start) flag_field("start_pos", want.start, start_pos);
				if (lexeme_length !== want.len)
					flag_field("lexeme_length", want.len, lexeme_length);
				if (line_number !== want.line) flag_field("line_number", want.line, line_number);
				if (last_of_run !== want.last) flag_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	// ---------------- run ----------------

	initial begin
		res_t hand;
		int target;
		fed_items     = 0;
		fail_count    = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		clear_scan();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows; obvious tokens replace the predicted ones
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].ch, dir_rows[i].has, dir_rows[i].fin);
			if (dir_rows[i].typed) begin
				repeat (run_count) void'(expected_tokens.pop_back());
				hand.kind  = dir_rows[i].kind;
				hand.err   = dir_rows[i].err;
				hand.start = dir_rows[i].start;
				hand.len   = dir_rows[i].len;
				hand.line  = dir_rows[i].line;
				hand.last  = 1'b1;
				queue_token(hand);
			end
		end

		// random sources under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			snd_idle_pct  = snd_phase_pct[ph];
			rcv_stall_pct = rcv_phase_pct[ph];
			target = fed_items + 100;
			while (fed_items < target) send_random_source();
		end
		in_valid = 1'b0;

		// drain, then keep watching for stray tokens before the verdict
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_tokens.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#15_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
